// File: hdl/tpcd_pkg.sv
// ----------------------------------------------------------------------------
// tpcd_pkg
// Shared types, byte codes and event helpers for the pattern channel decoder.
// ----------------------------------------------------------------------------
package tpcd_pkg;

  // default sizing
  localparam int STACK_DEPTH_DEF  = 16;
  localparam int SAMPLE_COUNT_DEF = 32;

  // command bytes with a meaning of their own
  localparam logic [7:0] B_NOENV_SMP  = 8'h10;
  localparam logic [7:0] B_ENV_LO_MIN = 8'h11;
  localparam logic [7:0] B_NOISE      = 8'h20;
  localparam logic [7:0] B_ORN        = 8'h40;
  localparam logic [7:0] B_NOTE       = 8'h50;
  localparam logic [7:0] B_NOENV      = 8'hb0;
  localparam logic [7:0] B_PERIOD     = 8'hb1;
  localparam logic [7:0] B_ENV_HI_MIN = 8'hb2;
  localparam logic [7:0] B_ENV_HI_MAX = 8'hbf;
  localparam logic [7:0] B_REST       = 8'hc0;
  localparam logic [7:0] B_END        = 8'hd0;
  localparam logic [7:0] B_ORN_SMP    = 8'hf0;

  // effect codes kept on the stack
  localparam logic [3:0] EFF_GLISS     = 4'd1;
  localparam logic [3:0] EFF_NOTEGLISS = 4'd2;
  localparam logic [3:0] EFF_SMPOFF    = 4'd3;
  localparam logic [3:0] EFF_ORNOFF    = 4'd4;
  localparam logic [3:0] EFF_VIBRATO   = 4'd5;
  localparam logic [3:0] EFF_ENVSLIDE  = 4'd8;
  localparam logic [3:0] EFF_TEMPO     = 4'd9;

  // event kinds
  localparam logic [4:0] K_ENVELOPE  = 5'd0;
  localparam logic [4:0] K_NOENV     = 5'd1;
  localparam logic [4:0] K_ORNAMENT  = 5'd2;
  localparam logic [4:0] K_SAMPLE    = 5'd3;
  localparam logic [4:0] K_NOISE     = 5'd4;
  localparam logic [4:0] K_VOLUME    = 5'd5;
  localparam logic [4:0] K_PERIOD    = 5'd6;
  localparam logic [4:0] K_REST      = 5'd7;
  localparam logic [4:0] K_NOTE      = 5'd8;
  localparam logic [4:0] K_GLISS     = 5'd9;
  localparam logic [4:0] K_NOTEGLISS = 5'd10;
  localparam logic [4:0] K_SMPOFF    = 5'd11;
  localparam logic [4:0] K_ORNOFF    = 5'd12;
  localparam logic [4:0] K_VIBRATO   = 5'd13;
  localparam logic [4:0] K_ENVSLIDE  = 5'd14;
  localparam logic [4:0] K_TEMPO     = 5'd15;
  localparam logic [4:0] K_DONE      = 5'd16;

  // byte interpretation phase
  typedef enum logic [5:0] {
    PH_CMD    = 6'b000001,
    PH_ENV_HI = 6'b000010,
    PH_ENV_LO = 6'b000100,
    PH_SAMPLE = 6'b001000,
    PH_PERIOD = 6'b010000,
    PH_EFFECT = 6'b100000
  } phase_t;

  // decoder state other than the effect stack
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held_command;
    logic [15:0] held_word;
    logic [7:0]  held_param;
    logic [2:0]  param_index;
    logic [7:0]  pend_term;
    logic        overflow;
  } st_t;

  localparam st_t ST_RESET = '{
    phase:        PH_CMD,
    held_command: 8'h00,
    held_word:    16'h0000,
    held_param:   8'h00,
    param_index:  3'd0,
    pend_term:    8'h00,
    overflow:     1'b0
  };

  // one decoded event
  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  arg_a;
    logic [15:0] arg_b;
    logic [15:0] arg_c;
    logic        row_last;
    logic        ovf;
  } evt_t;

  function automatic evt_t mk_ev(input logic [4:0] kind, input logic [7:0] a,
                                 input logic [15:0] b, input logic [15:0] c,
                                 input logic last, input logic ovf);
    evt_t e;
    e.kind     = kind;
    e.arg_a    = a;
    e.arg_b    = b;
    e.arg_c    = c;
    e.row_last = last;
    e.ovf      = ovf;
    return e;
  endfunction

  // closing event of a row that ends in a note or an end byte
  function automatic evt_t final_ev(input logic [7:0] term, input logic ovf);
    evt_t e;
    if (term == B_END) begin
      e = mk_ev(K_DONE, 8'h00, 16'h0000, 16'h0000, 1'b1, ovf);
    end else begin
      e = mk_ev(K_NOTE, term - B_NOTE, 16'h0000, 16'h0000, 1'b1, ovf);
    end
    return e;
  endfunction

endpackage

// File: hdl/tpcd_decode.sv
// ----------------------------------------------------------------------------
// tpcd_decode
// Combinational byte decoder: next state, stack control and up to two events.
// ----------------------------------------------------------------------------
module tpcd_decode #(
  parameter int STACK_DEPTH  = tpcd_pkg::STACK_DEPTH_DEF,
  parameter int SAMPLE_COUNT = tpcd_pkg::SAMPLE_COUNT_DEF,
  parameter int DW           = $clog2(STACK_DEPTH + 1)
) (
  input  logic [7:0]      data_byte,
  input  tpcd_pkg::st_t   st,
  input  logic [DW-1:0]   depth,
  input  logic [3:0]      top,
  output tpcd_pkg::st_t   st_nxt,
  output logic [DW-1:0]   depth_nxt,
  output logic            push,
  output logic [1:0]      ev_cnt,
  output tpcd_pkg::evt_t  ev0,
  output tpcd_pkg::evt_t  ev1
);
  import tpcd_pkg::*;

  logic [7:0]    v;
  logic [3:0]    code;
  logic          fin;
  logic [4:0]    fk;
  logic [7:0]    fa;
  logic [15:0]   fb;
  logic [15:0]   fc;
  logic [DW-1:0] d1;
  logic          is_eff;

  assign v = data_byte;
  assign d1 = depth - DW'(1);

  // codes that go on the effect stack
  assign is_eff = (v[3:0] >= EFF_GLISS && v[3:0] <= EFF_VIBRATO) ||
                  v[3:0] == EFF_ENVSLIDE || v[3:0] == EFF_TEMPO;

  always_comb begin
    st_nxt    = st;
    depth_nxt = depth;
    push      = 1'b0;
    ev_cnt    = 2'd0;
    ev0       = '0;
    ev1       = '0;
    fin       = 1'b0;
    fk        = '0;
    fa        = '0;
    fb        = '0;
    fc        = '0;
    code      = (depth == '0) ? EFF_TEMPO : top;

    unique case (st.phase)
      // tone word, high byte
      PH_ENV_HI: begin
        st_nxt.held_word = {v, 8'h00};
        st_nxt.phase     = PH_ENV_LO;
      end
      // tone word, low byte, then the envelope event
      PH_ENV_LO: begin
        st_nxt.held_word = {st.held_word[15:8], v};
        ev0 = mk_ev(K_ENVELOPE,
                    (st.held_command >= B_ENV_HI_MIN) ? st.held_command - B_PERIOD
                                                      : st.held_command - B_NOENV_SMP,
                    16'h0000, {st.held_word[15:8], v}, 1'b0, st.overflow);
        ev_cnt = 2'd1;
        st_nxt.phase = (st.held_command < B_ENV_HI_MIN) ? PH_SAMPLE : PH_CMD;
      end
      // sample byte with range check
      PH_SAMPLE: begin
        ev0 = mk_ev(K_SAMPLE,
                    ({1'b0, v} < 9'(2 * SAMPLE_COUNT) && !v[0]) ? {1'b0, v[7:1]} : 8'h00,
                    16'h0000, 16'h0000, 1'b0, st.overflow);
        ev_cnt = 2'd1;
        st_nxt.phase = PH_CMD;
      end
      PH_PERIOD: begin
        ev0 = mk_ev(K_PERIOD, v - 8'd1, 16'h0000, 16'h0000, 1'b0, st.overflow);
        ev_cnt = 2'd1;
        st_nxt.phase = PH_CMD;
      end
      // effect parameter bytes for the code on top of the stack
      PH_EFFECT: begin
        unique case (code)
          EFF_GLISS, EFF_ENVSLIDE: begin
            priority if (st.param_index == 3'd0) begin
              st_nxt.held_param  = v;
              st_nxt.param_index = 3'd1;
            end else if (st.param_index == 3'd1) begin
              st_nxt.held_command = v;
              st_nxt.param_index  = 3'd2;
            end else begin
              fin = 1'b1;
              fk  = (code == EFF_GLISS) ? K_GLISS : K_ENVSLIDE;
              fa  = st.held_param;
              fb  = {v, st.held_command};
            end
          end
          EFF_NOTEGLISS: begin
            priority if (st.param_index == 3'd0) begin
              st_nxt.held_param  = v;
              st_nxt.param_index = 3'd1;
            end else if (st.param_index == 3'd1 || st.param_index == 3'd3) begin
              st_nxt.held_command = v;
              st_nxt.param_index  = st.param_index + 3'd1;
            end else if (st.param_index == 3'd2) begin
              st_nxt.held_word   = {v, st.held_command};
              st_nxt.param_index = 3'd3;
            end else begin
              fin = 1'b1;
              fk  = K_NOTEGLISS;
              fa  = st.held_param;
              fb  = {v, st.held_command};
              fc  = st.held_word;
            end
          end
          EFF_SMPOFF: begin
            fin = 1'b1;
            fk  = K_SMPOFF;
            fa  = v;
          end
          EFF_ORNOFF: begin
            fin = 1'b1;
            fk  = K_ORNOFF;
            fa  = v;
          end
          EFF_VIBRATO: begin
            if (st.param_index == 3'd0) begin
              st_nxt.held_param  = v;
              st_nxt.param_index = 3'd1;
            end else begin
              fin = 1'b1;
              fk  = K_VIBRATO;
              fa  = st.held_param;
              fc  = {8'h00, v};
            end
          end
          default: begin
            fin = 1'b1;
            fk  = K_TEMPO;
            fa  = v;
          end
        endcase
      end
      // command byte
      default: begin
        st_nxt.phase = PH_CMD;
        priority if (v < B_NOENV_SMP) begin
          if (is_eff) begin
            if (depth < DW'(STACK_DEPTH)) begin
              push      = 1'b1;
              depth_nxt = depth + DW'(1);
            end else begin
              st_nxt.overflow = 1'b1;
            end
          end
        end else if (v < B_NOISE || (v >= B_ENV_HI_MIN && v <= B_ENV_HI_MAX) ||
                     v >= B_ORN_SMP) begin
          if (v >= B_ENV_LO_MIN && v <= B_ENV_HI_MAX) begin
            st_nxt.held_command = v;
            st_nxt.phase        = PH_ENV_HI;
          end else begin
            ev0 = mk_ev(K_NOENV, 8'h00, 16'h0000, 16'h0000, 1'b0, st.overflow);
            ev1 = mk_ev(K_ORNAMENT, v - B_ORN_SMP, 16'h0000, 16'h0000, 1'b0,
                        st.overflow);
            ev_cnt = (v >= B_ORN_SMP) ? 2'd2 : 2'd1;
            st_nxt.phase = PH_SAMPLE;
          end
        end else if (v < B_ORN) begin
          ev0 = mk_ev(K_NOISE, v - B_NOISE, 16'h0000, 16'h0000, 1'b0, st.overflow);
          ev_cnt = 2'd1;
        end else if (v < B_NOTE) begin
          ev0 = mk_ev(K_ORNAMENT, v - B_ORN, 16'h0000, 16'h0000, 1'b0, st.overflow);
          ev_cnt = 2'd1;
        end else if (v < B_NOENV || v == B_REST || v == B_END) begin
          // row terminator: note, rest or end byte
          st_nxt.pend_term   = v;
          st_nxt.param_index = 3'd0;
          if (v == B_REST) begin
            ev0 = mk_ev(K_REST, 8'h00, 16'h0000, 16'h0000, depth == '0, st.overflow);
            ev_cnt = 2'd1;
          end else if (depth == '0) begin
            ev0 = final_ev(v, st.overflow);
            ev_cnt = 2'd1;
          end
          if (depth == '0) begin
            st_nxt.phase     = PH_CMD;
            st_nxt.pend_term = 8'h00;
            st_nxt.overflow  = 1'b0;
          end else begin
            st_nxt.phase = PH_EFFECT;
          end
        end else if (v == B_NOENV) begin
          ev0 = mk_ev(K_NOENV, 8'h00, 16'h0000, 16'h0000, 1'b0, st.overflow);
          ev_cnt = 2'd1;
        end else if (v == B_PERIOD) begin
          st_nxt.phase = PH_PERIOD;
        end else if (v < B_END) begin
          ev0 = mk_ev(K_VOLUME, v - B_REST, 16'h0000, 16'h0000, 1'b0, st.overflow);
          ev_cnt = 2'd1;
        end else begin
          ev0 = mk_ev(K_SAMPLE, v - B_END, 16'h0000, 16'h0000, 1'b0, st.overflow);
          ev_cnt = 2'd1;
        end
      end
    endcase

    // effect complete: pop, and close the row when the stack runs empty
    if (fin) begin
      st_nxt.param_index = 3'd0;
      if (d1 == '0) begin
        if (st.pend_term == B_REST) begin
          ev0 = mk_ev(fk, fa, fb, fc, 1'b1, st.overflow);
          ev_cnt = 2'd1;
        end else begin
          ev0 = mk_ev(fk, fa, fb, fc, 1'b0, st.overflow);
          ev1 = final_ev(st.pend_term, st.overflow);
          ev_cnt = 2'd2;
        end
        st_nxt.phase     = PH_CMD;
        st_nxt.pend_term = 8'h00;
        st_nxt.overflow  = 1'b0;
        depth_nxt        = '0;
      end else begin
        ev0 = mk_ev(fk, fa, fb, fc, 1'b0, st.overflow);
        ev_cnt    = 2'd1;
        depth_nxt = d1;
      end
    end
  end

endmodule

// File: hdl/tracker_pattern_channel_decoder.sv
// A request is decoded in the cycle it is accepted; its events are registered into
// the event queue and offered on the result port in order.
// Throughput: one request per cycle while the four-entry event queue has room for
// two; output is one event per cycle while out_ready is high.
// Reset: synchronous, active low; clears phase, held fields, stack depth and the
// queue pointers. The effect stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
// tracker_pattern_channel_decoder
// Pattern-stream channel decoder: one byte per request, decoded events out
// through a small queue.
// ----------------------------------------------------------------------------
module tracker_pattern_channel_decoder #(
  parameter int STACK_DEPTH  = tpcd_pkg::STACK_DEPTH_DEF,
  parameter int SAMPLE_COUNT = tpcd_pkg::SAMPLE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_event_kind,
  output logic [7:0]         out_arg_a,
  output logic signed [15:0] out_arg_b,
  output logic [15:0]        out_arg_c,
  output logic               out_row_last,
  output logic               out_stack_overflow
);
  import tpcd_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  st_t           st_r;
  st_t           st_nxt;
  logic [DW-1:0] depth_r;
  logic [DW-1:0] depth_nxt;
  logic [DW-1:0] rd_dec;
  logic [AW-1:0] rd_addr;
  logic [3:0]    top_r;
  logic [3:0]    stack_mem [STACK_DEPTH];
  logic          push;
  logic [1:0]    ev_cnt;
  evt_t          ev0;
  evt_t          ev1;
  logic          in_fire;
  logic          out_fire;

  evt_t          q_mem [4];
  logic [1:0]    wp_r;
  logic [1:0]    rp_r;
  logic [2:0]    cnt_r;
  evt_t          head;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);

  // byte decoder
  tpcd_decode #(
    .STACK_DEPTH (STACK_DEPTH),
    .SAMPLE_COUNT(SAMPLE_COUNT),
    .DW          (DW)
  ) u_decode (
    .data_byte(in_data_byte),
    .st       (st_r),
    .depth    (depth_r),
    .top      (top_r),
    .st_nxt   (st_nxt),
    .depth_nxt(depth_nxt),
    .push     (push),
    .ev_cnt   (ev_cnt),
    .ev0      (ev0),
    .ev1      (ev1)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_RESET;
      depth_r <= '0;
    end else if (in_fire) begin
      st_r    <= st_nxt;
      depth_r <= depth_nxt;
    end
  end

  // effect stack: write on push, registered read of the new top
  assign rd_dec  = depth_nxt - DW'(1);
  assign rd_addr = rd_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire && push) begin
      stack_mem[depth_r[AW-1:0]] <= in_data_byte[3:0];
    end
    if (in_fire) begin
      top_r <= push ? in_data_byte[3:0] : stack_mem[rd_addr];
    end
  end

  // event queue storage
  always_ff @(posedge clk) begin
    if (in_fire && ev_cnt != 2'd0) begin
      q_mem[wp_r] <= ev0;
    end
    if (in_fire && ev_cnt == 2'd2) begin
      q_mem[wp_r + 2'd1] <= ev1;
    end
  end

  // event queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_fire) begin
        wp_r <= wp_r + ev_cnt;
      end
      if (out_fire) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + (in_fire ? {1'b0, ev_cnt} : 3'd0) - {2'b00, out_fire};
    end
  end

  // result port
  assign head               = q_mem[rp_r];
  assign out_event_kind     = head.kind;
  assign out_arg_a          = head.arg_a;
  assign out_arg_b          = signed'(head.arg_b);
  assign out_arg_c          = head.arg_c;
  assign out_row_last       = head.row_last;
  assign out_stack_overflow = head.ovf;

  // queue never holds more than its four entries
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("event queue overfilled");

  // stack depth stays within the configured size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("effect stack depth out of range");

  // overflow is only raised against a full stack
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.overflow) |-> depth_r == DW'(STACK_DEPTH))
    else $error("overflow raised with room on the stack");

  // effect phase always has an effect to read
  a_effect_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_EFFECT |-> depth_r != '0)
    else $error("effect phase with empty stack");

  // finishing the last effect closes the row
  a_row_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && st_r.phase == PH_EFFECT && depth_nxt == '0) |=>
      (st_r.phase == PH_CMD && !st_r.overflow && st_r.pend_term == 8'h00))
    else $error("row not closed after last effect");

endmodule
